// ===== design/rps_pkg.sv =====
// Shared types, widths and limits for the row profile segmenter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rps_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // Position counters index up to the largest row or region size.
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   // Register fields and per-row counts hold the limit itself.
   localparam int LIM_W = 13;
   localparam int CNT_W = 13;
   localparam int GRP_W = 12;
   localparam int PIX_W = 8;

   localparam logic [LIM_W-1:0] ROW_LENGTH_RESET = LIM_W'(640);
   localparam logic [LIM_W-1:0] ROW_TOTAL_RESET  = LIM_W'(480);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TOTAL  = 1'b1;

   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic [CNT_W-1:0] black_count;
      logic             row_blank;
      logic             group_opened;
      logic             group_closed;
      logic [ROW_W-1:0] closed_start;
      logic [ROW_W-1:0] closed_end;
      logic             frame_done;
      logic [GRP_W-1:0] group_total;
      logic             best_found;
      logic [ROW_W-1:0] best_start;
      logic [ROW_W-1:0] best_end;
   } rps_result_type;

   // Limits a register value to the range 1..hi.
   function automatic logic [LIM_W-1:0] clamp_limit(input logic [LIM_W-1:0] v,
                                                    input logic [LIM_W-1:0] hi);
      logic [LIM_W-1:0] r;
      if (v == '0) begin
         r = LIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/rps_in_stage.sv =====
// Input register of the row profile segmenter: holds one pixel byte.
// Depends on rps_pkg.
`default_nettype none

module rps_in_stage
   import rps_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [PIX_W-1:0] req_pixel_red,
   input  wire logic             consume,
   output logic                  pix_valid,
   output logic [PIX_W-1:0]      pix_red
);

   logic             valid_ff;
   logic             valid_in;
   logic [PIX_W-1:0] red_ff;

   // The register frees up in the same cycle that its pixel moves on.
   assign req_ready = !valid_ff || consume;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         red_ff <= req_pixel_red;
      end
   end

   assign pix_valid = valid_ff;
   assign pix_red   = red_ff;

endmodule

`default_nettype wire

// ===== design/rps_profile.sv =====
// Row profile state: column and row position, per-row foreground count,
// group tracking and the longest group. Depends on rps_pkg.
`default_nettype none

module rps_profile
   import rps_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [LIM_W-1:0] width,
   input  wire logic [LIM_W-1:0] height,
   input  wire logic             step,
   input  wire logic [PIX_W-1:0] pix_red,
   output logic                  row_end,
   output rps_result_type        result
);

   logic [COL_W-1:0] column_pos_ff;
   logic [ROW_W-1:0] row_pos_ff;
   logic [CNT_W-1:0] row_black_ff;
   logic             in_group_ff;
   logic [ROW_W-1:0] group_begin_ff;
   logic [GRP_W-1:0] groups_seen_ff;
   logic [ROW_W-1:0] longest_begin_ff;
   logic [ROW_W-1:0] longest_finish_ff;
   logic [CNT_W-1:0] longest_len_ff;
   logic             any_group_ff;

   logic [LIM_W-1:0] col_next;
   logic [CNT_W-1:0] count;
   logic             last_row;
   logic             opened;
   logic             active;
   logic             closed;
   logic [ROW_W-1:0] cs;
   logic [ROW_W-1:0] grp_len;
   logic             take_best;
   logic [GRP_W-1:0] groups_in;
   logic [ROW_W-1:0] best_begin_in;
   logic [ROW_W-1:0] best_finish_in;
   logic             any_group_in;

   always_comb begin
      count    = row_black_ff + CNT_W'(pix_red == '0);
      col_next = LIM_W'(column_pos_ff) + LIM_W'(1);
      row_end  = col_next >= width;
      last_row = (LIM_W'(row_pos_ff) + LIM_W'(1)) >= height;

      opened = !in_group_ff && (count != '0);
      active = in_group_ff || opened;
      // A blank row closes the group it follows; the last row closes any group.
      closed = active && ((count == '0) || last_row);
      cs     = opened ? row_pos_ff : group_begin_ff;

      grp_len   = row_pos_ff - cs;
      take_best = closed && (!any_group_ff || (CNT_W'(grp_len) > longest_len_ff));
      groups_in = groups_seen_ff + GRP_W'(opened);

      best_begin_in  = take_best ? cs : longest_begin_ff;
      best_finish_in = take_best ? row_pos_ff : longest_finish_ff;
      any_group_in   = any_group_ff || closed;

      result.row_index    = row_pos_ff;
      result.black_count  = count;
      result.row_blank    = (count == '0);
      result.group_opened = opened;
      result.group_closed = closed;
      result.closed_start = closed ? cs : '0;
      result.closed_end   = closed ? row_pos_ff : '0;
      result.frame_done   = last_row;
      result.group_total  = groups_in;
      result.best_found   = any_group_in;
      result.best_start   = any_group_in ? best_begin_in : '0;
      result.best_end     = any_group_in ? best_finish_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff     <= '0;
         row_pos_ff        <= '0;
         row_black_ff      <= '0;
         in_group_ff       <= 1'b0;
         group_begin_ff    <= '0;
         groups_seen_ff    <= '0;
         longest_begin_ff  <= '0;
         longest_finish_ff <= '0;
         longest_len_ff    <= '0;
         any_group_ff      <= 1'b0;
      end else if (step) begin
         if (!row_end) begin
            column_pos_ff <= col_next[COL_W-1:0];
            row_black_ff  <= count;
         end else begin
            column_pos_ff <= '0;
            row_black_ff  <= '0;
            if (last_row) begin
               row_pos_ff        <= '0;
               in_group_ff       <= 1'b0;
               group_begin_ff    <= '0;
               groups_seen_ff    <= '0;
               longest_begin_ff  <= '0;
               longest_finish_ff <= '0;
               longest_len_ff    <= '0;
               any_group_ff      <= 1'b0;
            end else begin
               row_pos_ff     <= row_pos_ff + ROW_W'(1);
               in_group_ff    <= active && !closed;
               group_begin_ff <= cs;
               groups_seen_ff <= groups_in;
               any_group_ff   <= any_group_in;
               if (take_best) begin
                  longest_begin_ff  <= cs;
                  longest_finish_ff <= row_pos_ff;
                  longest_len_ff    <= CNT_W'(grp_len);
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/rps_out_stage.sv =====
// Result register of the row profile segmenter: one row result and its valid.
// Depends on rps_pkg.
`default_nettype none

module rps_out_stage
   import rps_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire rps_result_type result,
   output logic          can_take,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rps_result_type held
);

   logic           valid_ff;
   rps_result_type data_ff;

   assign can_take = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign held      = data_ff;

endmodule

`default_nettype wire

// ===== design/row_profile_segmenter.sv =====
// Row profile segmenter: counts foreground pixels per row and reports runs
// of non-blank rows. Depends on rps_pkg, rps_in_stage, rps_profile, rps_out_stage.
//
// Usage:
//   Pixels come in on the req_ channel in raster order, one red byte per
//   transfer; a red value of zero is foreground. One result leaves on the
//   rsp_ channel for each finished row, none for other pixels.
//   The csr_ channel writes row_length (index 0) and row_total (index 1);
//   it is always ready and should be used only while the block is idle.
//   A pixel transfer lands in the input register; from there it updates the
//   profile state and, at a row end, loads the result register, which offers
//   the result. One pixel is taken per cycle unless a row-ending pixel waits.
//   When the receiver stalls, the result register holds; pixels that end no
//   row keep flowing, and the next row-ending pixel waits in the input
//   register until the result is taken.
//   After the last row of a region the group state clears for the next one.
//   Reset empties both registers, zeroes all positions and counters and
//   sets row_length to 640 and row_total to 480.
`default_nettype none

module row_profile_segmenter
   import rps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [PIX_W-1:0]     req_pixel_red,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [ROW_W-1:0]          rsp_row_index,
   output logic [CNT_W-1:0]          rsp_black_count,
   output logic                      rsp_row_blank,
   output logic                      rsp_group_opened,
   output logic                      rsp_group_closed,
   output logic [ROW_W-1:0]          rsp_closed_start,
   output logic [ROW_W-1:0]          rsp_closed_end,
   output logic                      rsp_frame_done,
   output logic [GRP_W-1:0]          rsp_group_total,
   output logic                      rsp_best_found,
   output logic [ROW_W-1:0]          rsp_best_start,
   output logic [ROW_W-1:0]          rsp_best_end,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [LIM_W-1:0]     csr_data
);

   logic [LIM_W-1:0] row_length_ff;
   logic [LIM_W-1:0] row_total_ff;
   logic [LIM_W-1:0] width;
   logic [LIM_W-1:0] height;

   logic             pix_valid;
   logic [PIX_W-1:0] pix_red;
   logic             consume;
   logic             row_end;
   logic             can_take;
   logic             step;
   rps_result_type   result;
   rps_result_type   held;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_total_ff  <= ROW_TOTAL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_LENGTH: row_length_ff <= csr_data;
            CSR_ROW_TOTAL:  row_total_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign width  = clamp_limit(row_length_ff, LIM_W'(MAX_WIDTH));
   assign height = clamp_limit(row_total_ff, LIM_W'(MAX_HEIGHT));

   // A pixel that ends a row moves on only when the result register is free.
   assign consume = pix_valid && (!row_end || can_take);
   assign step    = consume;

   rps_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_red (req_pixel_red),
      .consume       (consume),
      .pix_valid     (pix_valid),
      .pix_red       (pix_red)
   );

   rps_profile u_profile (
      .clock   (clock),
      .reset   (reset),
      .width   (width),
      .height  (height),
      .step    (step),
      .pix_red (pix_red),
      .row_end (row_end),
      .result  (result)
   );

   rps_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step && row_end),
      .result    (result),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .held      (held)
   );

   assign rsp_row_index    = held.row_index;
   assign rsp_black_count  = held.black_count;
   assign rsp_row_blank    = held.row_blank;
   assign rsp_group_opened = held.group_opened;
   assign rsp_group_closed = held.group_closed;
   assign rsp_closed_start = held.closed_start;
   assign rsp_closed_end   = held.closed_end;
   assign rsp_frame_done   = held.frame_done;
   assign rsp_group_total  = held.group_total;
   assign rsp_best_found   = held.best_found;
   assign rsp_best_start   = held.best_start;
   assign rsp_best_end     = held.best_end;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for row_profile_segmenter: it streams pixel rows into the block
// and checks each row result against a behavioral profile of the rows and runs.
// Depends on rps_pkg and the row_profile_segmenter RTL; needs no other file.

module tb_top
   import rps_pkg::*;
();

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel_red = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ROW_W-1:0]     rsp_row_index;
   logic [CNT_W-1:0]     rsp_black_count;
   logic                 rsp_row_blank;
   logic                 rsp_group_opened;
   logic                 rsp_group_closed;
   logic [ROW_W-1:0]     rsp_closed_start;
   logic [ROW_W-1:0]     rsp_closed_end;
   logic                 rsp_frame_done;
   logic [GRP_W-1:0]     rsp_group_total;
   logic                 rsp_best_found;
   logic [ROW_W-1:0]     rsp_best_start;
   logic [ROW_W-1:0]     rsp_best_end;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROW_LENGTH;
   logic [LIM_W-1:0]     csr_data = '0;

   row_profile_segmenter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_red    (req_pixel_red),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_index    (rsp_row_index),
      .rsp_black_count  (rsp_black_count),
      .rsp_row_blank    (rsp_row_blank),
      .rsp_group_opened (rsp_group_opened),
      .rsp_group_closed (rsp_group_closed),
      .rsp_closed_start (rsp_closed_start),
      .rsp_closed_end   (rsp_closed_end),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_group_total  (rsp_group_total),
      .rsp_best_found   (rsp_best_found),
      .rsp_best_start   (rsp_best_start),
      .rsp_best_end     (rsp_best_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #6 clock = ~clock;

   // Profile state that mirrors the block.
   logic [LIM_W-1:0] cfg_row_length;
   logic [LIM_W-1:0] cfg_row_total;
   logic [COL_W-1:0] col_pos;
   logic [ROW_W-1:0] row_pos;
   logic [CNT_W-1:0] black_acc;
   logic             run_open;
   logic [ROW_W-1:0] run_begin;
   logic [GRP_W-1:0] run_count;
   logic [ROW_W-1:0] long_begin;
   logic [ROW_W-1:0] long_end;
   logic [CNT_W-1:0] long_len;
   logic             long_valid;

   rps_result_type   expected_rows[$];
   int               mismatches = 0;
   int               pixels_sent = 0;
   bit               idle_mode = 1'b1;
   bit               row_inked = 1'b0;
   int               stall_left = 0;

   function automatic logic [LIM_W-1:0] bound_size(input logic [LIM_W-1:0] v, input int hi);
      return (v == '0) ? LIM_W'(1) : ((int'(v) > hi) ? LIM_W'(hi) : v);
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_mode || roll < 70) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Rows are either blank or inked; inked rows are about half foreground. A few pixels
   // are fully random so that blank rows sometimes pick up a stray foreground pixel.
   function automatic logic [PIX_W-1:0] pick_red();
      if (col_pos == '0) begin
         row_inked = ($urandom_range(0, 9) >= 4);
      end
      if ($urandom_range(0, 9) == 0) begin
         return PIX_W'($urandom_range(0, 255));
      end
      if (row_inked && $urandom_range(0, 1) == 1) begin
         return '0;
      end
      return PIX_W'($urandom_range(1, 255));
   endfunction

   task automatic clear_groups();
      row_pos    = '0;
      run_open   = 1'b0;
      run_begin  = '0;
      run_count  = '0;
      long_begin = '0;
      long_end   = '0;
      long_len   = '0;
      long_valid = 1'b0;
   endtask

   task automatic reset_profile();
      cfg_row_length = LIM_W'(640);
      cfg_row_total  = LIM_W'(480);
      col_pos        = '0;
      black_acc      = '0;
      clear_groups();
   endtask

   task automatic profile_pixel(input logic [PIX_W-1:0] red);
      logic [LIM_W-1:0] w;
      logic [LIM_W-1:0] h;
      logic [LIM_W-1:0] col_next;
      logic [LIM_W-1:0] span;
      logic [ROW_W-1:0] row;
      logic [CNT_W-1:0] count;
      logic             at_last;
      rps_result_type   r;
      w = bound_size(cfg_row_length, MAX_WIDTH);
      h = bound_size(cfg_row_total, MAX_HEIGHT);
      if (red == '0) begin
         black_acc = black_acc + CNT_W'(1);
      end
      col_next = LIM_W'(col_pos) + LIM_W'(1);
      // A row ends once the position reaches or passes the width, even a width just lowered.
      if (col_next < w) begin
         col_pos = col_next[COL_W-1:0];
      end else begin
         col_pos   = '0;
         count     = black_acc;
         black_acc = '0;
         row       = row_pos;
         at_last   = (LIM_W'(row) + LIM_W'(1)) >= h;
         r               = '0;
         r.row_index     = row;
         r.black_count   = count;
         r.row_blank     = (count == '0);
         if (!run_open && count != '0) begin
            run_open       = 1'b1;
            r.group_opened = 1'b1;
            run_begin      = row;
            run_count      = run_count + GRP_W'(1);
         end
         if (run_open && (count == '0 || at_last)) begin
            run_open       = 1'b0;
            r.group_closed = 1'b1;
            r.closed_start = run_begin;
            r.closed_end   = row;
            span = (row >= run_begin) ? LIM_W'(row - run_begin) : '0;
            // Ties keep the earlier run.
            if (!long_valid || span > long_len) begin
               long_begin = run_begin;
               long_end   = row;
               long_len   = span;
            end
            long_valid = 1'b1;
         end
         r.frame_done  = at_last;
         r.group_total = run_count;
         r.best_found  = long_valid;
         r.best_start  = long_valid ? long_begin : '0;
         r.best_end    = long_valid ? long_end : '0;
         expected_rows.push_back(r);
         if (at_last) begin
            clear_groups();
         end else begin
            row_pos = row + ROW_W'(1);
         end
      end
   endtask

   // Valid stays high from one transfer to the next unless a gap is taken.
   task automatic send_pixel(input logic [PIX_W-1:0] red);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_red <= red;
      do @(posedge clock); while (!req_ready);
      profile_pixel(red);
      pixels_sent++;
   endtask

   // Writes both registers back to back; only called while the block is idle.
   task automatic set_region(input logic [LIM_W-1:0] len, input logic [LIM_W-1:0] rows);
      csr_valid <= 1'b1;
      csr_index <= CSR_ROW_LENGTH;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      cfg_row_length = len;
      csr_index <= CSR_ROW_TOTAL;
      csr_data  <= rows;
      do @(posedge clock); while (!csr_ready);
      cfg_row_total = rows;
      csr_valid <= 1'b0;
   endtask

   // A pixel that ends no row may still sit in the input register after the last result.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rows.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_basic_groups();
      logic [PIX_W-1:0] trailing_run [12] = '{8'd255, 8'd1, 8'd128, 8'd0, 8'd0, 8'd0,
                                              8'd0, 8'd200, 8'd0, 8'd0, 8'd64, 8'd2};
      logic [PIX_W-1:0] tied_runs [12] = '{8'd0, 8'd7, 8'd9, 8'd17, 8'd34, 8'd68,
                                           8'd9, 8'd0, 8'd9, 8'd127, 8'd0, 8'd254};
      set_region(LIM_W'(3), LIM_W'(4));
      foreach (trailing_run[i]) send_pixel(trailing_run[i]);
      foreach (tied_runs[i]) send_pixel(tied_runs[i]);
   endtask

   task automatic test_last_row_group();
      settle();
      set_region(LIM_W'(2), LIM_W'(3));
      send_pixel(8'd0);
      send_pixel(8'd0);
      send_pixel(8'd5);
      send_pixel(8'd5);
      send_pixel(8'd0);
      send_pixel(8'd255);
      // A region with no foreground at all never reports a best run.
      settle();
      set_region(LIM_W'(1), LIM_W'(2));
      send_pixel(8'd1);
      send_pixel(8'd255);
   endtask

   // A full-size row would take thousands of pixels, so each wide row is cut short by
   // lowering the limit, which ends it on the next pixel.
   task automatic test_size_extremes();
      settle();
      set_region(LIM_W'(MAX_WIDTH), LIM_W'(1));
      repeat (120) send_pixel('0);
      settle();
      set_region('0, '1);
      repeat (120) send_pixel(pick_red());
      settle();
      set_region('1, LIM_W'(MAX_HEIGHT));
      repeat (60) send_pixel(pick_red());
   endtask

   task automatic test_mid_region_change();
      settle();
      set_region(LIM_W'(6), LIM_W'(5));
      repeat (16) send_pixel(pick_red());
      // Both limits drop below the current position, so the next pixel ends row and region.
      settle();
      set_region(LIM_W'(2), LIM_W'(2));
      repeat (6) send_pixel(pick_red());
   endtask

   task automatic test_random_regions();
      int len;
      int rows;
      int budget;
      int target;
      target = 900;
      while (pixels_sent < target) begin
         settle();
         case ($urandom_range(0, 15))
            0:       len = 0;
            1:       len = $urandom_range(MAX_WIDTH + 1, 8191);
            default: len = $urandom_range(1, 10);
         endcase
         case ($urandom_range(0, 7))
            0:       rows = 0;
            1:       rows = $urandom_range(MAX_HEIGHT + 1, 8191);
            default: rows = $urandom_range(1, 12);
         endcase
         idle_mode = ($urandom_range(0, 3) != 0);
         set_region(LIM_W'(len), LIM_W'(rows));
         budget = int'(bound_size(LIM_W'(len), MAX_WIDTH));
         budget = budget * int'(bound_size(LIM_W'(rows), MAX_HEIGHT)) * $urandom_range(1, 3)
                  + $urandom_range(0, budget - 1);
         if (budget > 150) begin
            budget = $urandom_range(40, 150);
         end
         repeat (budget) send_pixel(pick_red());
      end
      idle_mode = 1'b1;
   endtask

   function automatic void check_field(input string name, input logic [ROW_W-1:0] row,
                                       input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("row %0d: %s expected %0d, got %0d", row, name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      rps_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("row %0d: result transfer with no row pending", rsp_row_index);
            end
         end else begin
            want = expected_rows.pop_front();
            check_field("row_index", want.row_index, 16'(want.row_index),
                        16'(rsp_row_index));
            check_field("black_count", want.row_index, 16'(want.black_count),
                        16'(rsp_black_count));
            check_field("row_blank", want.row_index, 16'(want.row_blank),
                        16'(rsp_row_blank));
            check_field("group_opened", want.row_index, 16'(want.group_opened),
                        16'(rsp_group_opened));
            check_field("group_closed", want.row_index, 16'(want.group_closed),
                        16'(rsp_group_closed));
            check_field("closed_start", want.row_index, 16'(want.closed_start),
                        16'(rsp_closed_start));
            check_field("closed_end", want.row_index, 16'(want.closed_end),
                        16'(rsp_closed_end));
            check_field("frame_done", want.row_index, 16'(want.frame_done),
                        16'(rsp_frame_done));
            check_field("group_total", want.row_index, 16'(want.group_total),
                        16'(rsp_group_total));
            check_field("best_found", want.row_index, 16'(want.best_found),
                        16'(rsp_best_found));
            check_field("best_start", want.row_index, 16'(want.best_start),
                        16'(rsp_best_start));
            check_field("best_end", want.row_index, 16'(want.best_end),
                        16'(rsp_best_end));
         end
      end
   end

   initial begin
      reset_profile();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_basic_groups();
      test_last_row_group();
      test_size_extremes();
      test_mid_region_change();
      test_random_regions();
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_rows.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(12 * 2_500_000);
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/rps_pkg.sv
design/rps_in_stage.sv
design/rps_profile.sv
design/rps_out_stage.sv
design/row_profile_segmenter.sv
bench/tb_top.sv
